### hw/rtl/lpg_pkg.sv
// Shared types, codes and color helpers for the LED strip pattern generator.
package lpg_pkg;

    localparam int STEP_W    = 11;
    localparam int OUT_STEP_W = 10;
    localparam int COLOR_W   = 24;
    localparam int CH_W      = 8;
    localparam int IDX_W     = 8;
    localparam int MODE_W    = 3;
    localparam int CFG_IDX_W = 3;

    // effect codes
    localparam logic [MODE_W-1:0] MODE_FADE    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SCAN    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WIPE    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RAINBOW = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CHASE   = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_A       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_B       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EYE_SIZE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_REVERSE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RAINBOW_CHASE = 3'd5;

    // opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_READ = 1'b1;

    // reset values
    localparam logic [COLOR_W-1:0] COLOR_A_RESET  = 24'hFF0000;
    localparam logic [CH_W-1:0]    EYE_SIZE_RESET = 8'd4;

    // color wheel
    localparam logic [CH_W-1:0] CH_MAX           = 8'd255;
    localparam logic [CH_W-1:0] WHEEL_THIRD      = 8'd85;
    localparam logic [CH_W-1:0] WHEEL_TWO_THIRDS = 8'd170;
    localparam int              WHEEL_SPAN       = 256;
    localparam int              RAINBOW_PERIOD   = 255;

    // x / 10 == (x * 205) >> 11 for any 8-bit x
    localparam logic [15:0] DIV10_MUL   = 16'd205;
    localparam int          DIV10_SHIFT = 11;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [COLOR_W-1:0] color_a;
        logic [COLOR_W-1:0] color_b;
        logic [CH_W-1:0]    eye_size;
        logic               rainbow_chase;
    } lpg_cfg_t;

    function automatic logic [COLOR_W-1:0] wheel(input logic [CH_W-1:0] pos);
        logic [CH_W-1:0] p;
        logic [CH_W-1:0] p3;
        p = CH_MAX - pos;
        if (p < WHEEL_THIRD)
        begin
            p3 = CH_W'(p * 3);
            wheel = {CH_MAX - p3, 8'd0, p3};
        end
        else if (p < WHEEL_TWO_THIRDS)
        begin
            p3 = CH_W'((p - WHEEL_THIRD) * 3);
            wheel = {8'd0, p3, CH_MAX - p3};
        end
        else
        begin
            p3 = CH_W'((p - WHEEL_TWO_THIRDS) * 3);
            wheel = {p3, CH_MAX - p3, 8'd0};
        end
    endfunction

    function automatic logic [CH_W-1:0] div10(input logic [CH_W-1:0] x);
        logic [15:0] prod;
        prod = {8'd0, x} * DIV10_MUL;
        div10 = CH_W'(prod >> DIV10_SHIFT);
    endfunction

endpackage

### hw/rtl/lpg_frame_mem.sv
// Frame buffer: one write port, one registered read port, per-pixel valid bits.
module lpg_frame_mem
    import lpg_pkg::*;
#(
    parameter int NUM_PIXELS = 256,
    localparam int AW = $clog2(NUM_PIXELS)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [COLOR_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output logic [COLOR_W-1:0] rd_data
);

    logic [COLOR_W-1:0]    pixel_mem [NUM_PIXELS];
    logic [NUM_PIXELS-1:0] valid_reg;
    logic [COLOR_W-1:0]    rdata_reg;
    logic                  rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pixel_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= pixel_mem[rd_addr];
        end
    end

    // never-written pixels read as black
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvalid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rvalid_reg ? rdata_reg : '0;

endmodule

### hw/rtl/lpg_render.sv
// Frame renderer: per-tick setup, then a sweep over the strip, one pixel per cycle; wipe writes only its target pixel.
module lpg_render
    import lpg_pkg::*;
#(
    parameter int NUM_PIXELS = 256,
    localparam int AW = $clog2(NUM_PIXELS)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  lpg_cfg_t                 cfg,
    input  logic signed [STEP_W-1:0] step,
    output logic                     wr_en,
    output logic [AW-1:0]            wr_addr,
    output logic [COLOR_W-1:0]       wr_data,
    output logic                     done
);

    localparam int SW   = STEP_W + 1;
    localparam int QUOT = WHEEL_SPAN / NUM_PIXELS;
    localparam int REM  = WHEEL_SPAN % NUM_PIXELS;
    localparam int RW   = $clog2(2 * NUM_PIXELS);
    localparam logic signed [SW-1:0] N_S        = SW'(NUM_PIXELS);
    localparam logic [19:0]          MOD3_MUL   = 20'd683;
    localparam int                   MOD3_SHIFT = 11;

    typedef enum logic [1:0] {R_IDLE, R_PREP, R_SWEEP} rstate_t;

    rstate_t              state_reg;
    logic [AW-1:0]        pix_reg;
    logic [CH_W-1:0]      wpos_reg;    // floor(i * 256 / N)
    logic [RW-1:0]        rem_reg;     // (i * 256) mod N
    logic [1:0]           ph_reg;      // (i + step) mod 3
    logic [COLOR_W-1:0]   fade_color_reg;
    logic [COLOR_W-1:0]   dim_color_reg;
    logic [COLOR_W-1:0]   wipe_color_reg;
    logic signed [SW-1:0] wipe_tgt_reg;

    logic signed [SW-1:0] step_s;
    logic [9:0]           s_mag;
    logic [19:0]          m3_prod;
    logic [8:0]           m3_quo;
    logic [9:0]           m3_rem;
    logic [COLOR_W-1:0]   fade_color;
    logic [COLOR_W-1:0]   dim_color;
    logic [COLOR_W-1:0]   wipe_color;
    logic signed [SW-1:0] wipe_tgt;
    logic [RW-1:0]        rem_sum;
    logic                 last_pix;
    logic signed [SW-1:0] pix_s;
    logic signed [SW-1:0] eye_s;
    logic signed [SW-1:0] pix_off;
    logic [COLOR_W-1:0]   wheel_color;

    function automatic logic [CH_W-1:0] fade_chan(input logic signed [STEP_W-1:0] s,
                                                  input logic [CH_W-1:0] c);
        logic [17:0] prod;
        logic [9:0]  scaled;
        prod   = {8'd0, s[9:0]} * {10'd0, c};
        scaled = prod[17:8];
        if (s < 0)
        begin
            fade_chan = '0;
        end
        else if (scaled > 10'(CH_MAX))
        begin
            fade_chan = CH_MAX;
        end
        else
        begin
            fade_chan = scaled[CH_W-1:0];
        end
    endfunction

    // per-tick setup
    always_comb
    begin
        step_s  = {step[STEP_W-1], step};
        s_mag   = step[9:0];
        m3_prod = {10'd0, s_mag} * MOD3_MUL;
        m3_quo  = m3_prod[19:MOD3_SHIFT];
        m3_rem  = s_mag - ({1'b0, m3_quo} * 10'd3);
        fade_color = {fade_chan(step, cfg.color_a[23:16]),
                      fade_chan(step, cfg.color_a[15:8]),
                      fade_chan(step, cfg.color_a[7:0])};
        dim_color  = {div10(cfg.color_a[23:16]),
                      div10(cfg.color_a[15:8]),
                      div10(cfg.color_a[7:0])};
        if (step_s < N_S)
        begin
            wipe_tgt   = step_s;
            wipe_color = cfg.color_a;
        end
        else
        begin
            wipe_tgt   = step_s - N_S;
            wipe_color = '0;
        end
    end

    assign last_pix = (pix_reg == AW'(NUM_PIXELS - 1));
    assign rem_sum  = rem_reg + RW'(REM);
    assign done     = (state_reg == R_SWEEP) && last_pix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
        end
        else
        begin
            unique case (state_reg)
                R_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= R_PREP;
                    end
                end
                R_PREP:  state_reg <= R_SWEEP;
                R_SWEEP:
                begin
                    if (last_pix)
                    begin
                        state_reg <= R_IDLE;
                    end
                end
                default: state_reg <= R_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == R_PREP)
        begin
            pix_reg        <= '0;
            wpos_reg       <= '0;
            rem_reg        <= '0;
            ph_reg         <= m3_rem[1:0];
            fade_color_reg <= fade_color;
            dim_color_reg  <= dim_color;
            wipe_color_reg <= wipe_color;
            wipe_tgt_reg   <= wipe_tgt;
        end
        else if (state_reg == R_SWEEP)
        begin
            pix_reg <= pix_reg + 1'b1;
            ph_reg  <= (ph_reg == 2'd2) ? 2'd0 : ph_reg + 2'd1;
            if (rem_sum >= RW'(NUM_PIXELS))
            begin
                rem_reg  <= rem_sum - RW'(NUM_PIXELS);
                wpos_reg <= wpos_reg + CH_W'(QUOT + 1);
            end
            else
            begin
                rem_reg  <= rem_sum;
                wpos_reg <= wpos_reg + CH_W'(QUOT);
            end
        end
    end

    // pixel color for the current sweep position
    always_comb
    begin
        pix_s       = $signed({{(SW-AW){1'b0}}, pix_reg});
        eye_s       = $signed({{(SW-CH_W){1'b0}}, cfg.eye_size});
        pix_off     = pix_s - step_s;
        wheel_color = wheel(wpos_reg + step[CH_W-1:0]);
        wr_en       = 1'b0;
        wr_data     = '0;
        unique case (cfg.mode)
            MODE_FADE:
            begin
                wr_en   = 1'b1;
                wr_data = fade_color_reg;
            end
            MODE_SCAN:
            begin
                wr_en = 1'b1;
                if (pix_off == 0 || pix_off == eye_s + 1)
                begin
                    wr_data = dim_color_reg;
                end
                else if (pix_off > 0 && pix_off <= eye_s)
                begin
                    wr_data = cfg.color_a;
                end
                else
                begin
                    wr_data = '0;
                end
            end
            MODE_WIPE:
            begin
                wr_en   = (pix_s == wipe_tgt_reg);
                wr_data = wipe_color_reg;
            end
            MODE_RAINBOW:
            begin
                wr_en   = 1'b1;
                wr_data = wheel_color;
            end
            MODE_CHASE:
            begin
                wr_en = 1'b1;
                if (ph_reg != 2'd0)
                begin
                    wr_data = cfg.color_b;
                end
                else if (cfg.rainbow_chase)
                begin
                    wr_data = wheel_color;
                end
                else
                begin
                    wr_data = cfg.color_a;
                end
            end
            default:
            begin
                wr_en   = 1'b0;
                wr_data = '0;
            end
        endcase
        if (state_reg != R_SWEEP)
        begin
            wr_en = 1'b0;
        end
    end

    assign wr_addr = pix_reg;

endmodule

### hw/rtl/lpg_step_unit.sv
// Animation step advance: bounce or wrap depending on the effect.
module lpg_step_unit
    import lpg_pkg::*;
#(
    parameter int NUM_PIXELS = 256
)
(
    input  logic [MODE_W-1:0]        mode,
    input  logic [CH_W-1:0]          eye_size,
    input  logic signed [STEP_W-1:0] step,
    input  logic                     rev,
    output logic signed [STEP_W-1:0] step_next,
    output logic                     rev_next
);

    localparam int SW = STEP_W + 1;
    localparam logic signed [SW-1:0] ONE_S          = SW'(1);
    localparam logic signed [SW-1:0] ZERO_S         = '0;
    localparam logic signed [SW-1:0] FADE_LIMIT     = SW'(WHEEL_SPAN);
    localparam logic signed [SW-1:0] SCAN_BASE      = SW'(NUM_PIXELS - 2);
    localparam logic signed [SW-1:0] WIPE_PERIOD    = SW'(2 * NUM_PIXELS);
    localparam logic signed [SW-1:0] RAINBOW_PER    = SW'(RAINBOW_PERIOD);
    localparam logic signed [SW-1:0] CHASE_PERIOD   = SW'(NUM_PIXELS);

    logic signed [SW-1:0] step_s;
    logic signed [SW-1:0] inc;
    logic signed [SW-1:0] dec;
    logic signed [SW-1:0] limit;
    logic signed [SW-1:0] period;
    logic signed [SW-1:0] nxt;

    always_comb
    begin
        step_s   = {step[STEP_W-1], step};
        inc      = step_s + ONE_S;
        dec      = step_s - ONE_S;
        limit    = (mode == MODE_SCAN)
                 ? SCAN_BASE - $signed({{(SW-CH_W){1'b0}}, eye_size})
                 : FADE_LIMIT;
        period   = CHASE_PERIOD;
        nxt      = step_s;
        rev_next = rev;
        unique case (mode)
            MODE_FADE, MODE_SCAN:
            begin
                if (!rev)
                begin
                    nxt = inc;
                    if (inc > limit)
                    begin
                        rev_next = 1'b1;
                    end
                end
                else
                begin
                    nxt = dec;
                    if (dec <= ZERO_S)
                    begin
                        rev_next = 1'b0;
                    end
                end
            end
            MODE_WIPE, MODE_RAINBOW, MODE_CHASE:
            begin
                if (mode == MODE_WIPE)
                begin
                    period = WIPE_PERIOD;
                end
                else if (mode == MODE_RAINBOW)
                begin
                    period = RAINBOW_PER;
                end
                if (!rev)
                begin
                    nxt = (inc >= period) ? ZERO_S : inc;
                end
                else
                begin
                    nxt = (dec <= ZERO_S) ? period - ONE_S : dec;
                end
            end
            default:
            begin
                nxt = step_s;
            end
        endcase
        step_next = nxt[STEP_W-1:0];
    end

endmodule

### hw/rtl/led_strip_pattern_generator_top.sv
// Top level of the LED strip pattern generator: registers, sequencer and result register.
//
// Pixel frame generator. The frame buffer (NUM_PIXELS x 24-bit packed rgb) sits
// in a single-port-write, registered-read memory and reads as black after reset
// through per-pixel valid bits, so there is no clearing pass and the block is
// ready in the first cycle after reset. An input transaction with opcode tick
// renders one frame of the selected effect (fade, scanner, wipe, rainbow,
// theater chase) and then advances the animation step; opcode read only looks
// up a pixel. Both return the color of pixel_index and the step after the
// access, one result per input transaction. A tick spends a setup step (fade
// scale, dimmed eye color, chase phase), then writes one pixel per cycle through
// the frame buffer write port, which sets the rate; then it reads the buffer and
// loads the result register. A read skips the setup and the sweep and only reads
// the buffer and loads the result register. Either load waits while an earlier
// result is still held unaccepted. A tick with an unused effect code still
// sweeps but writes nothing. One item is worked on at a time; a finished result
// waits in the output register while the next input transaction is accepted.
// Configuration writes are taken every cycle and must only be issued while no
// item is in flight; writing effect_mode resets the step to zero and loads the
// direction from start_reverse (always forward for the scanner).
module led_strip_pattern_generator_top
    import lpg_pkg::*;
#(
    parameter int NUM_PIXELS = 256
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [COLOR_W-1:0]           cfg_data,
    // input channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         opcode,
    input  logic [IDX_W-1:0]             pixel_index,
    // result channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [COLOR_W-1:0]           pixel_color,
    output logic signed [OUT_STEP_W-1:0] step_now
);

    localparam int AW = $clog2(NUM_PIXELS);
    localparam logic [IDX_W:0] NUM_PIX_W = (IDX_W + 1)'(NUM_PIXELS);

    typedef enum logic [1:0] {ST_IDLE, ST_RENDER, ST_READ, ST_RESP} state_t;

    state_t                      state_reg;
    lpg_cfg_t                    cfg_reg;
    logic                        start_reverse_reg;
    logic signed [STEP_W-1:0]    step_reg;
    logic                        rev_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic                        out_valid_reg;
    logic [COLOR_W-1:0]          pixel_color_reg;
    logic signed [OUT_STEP_W-1:0] step_now_reg;

    logic                        cfg_fire;
    logic                        in_fire;
    logic                        resp_load;
    logic                        render_start;
    logic                        render_done;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [COLOR_W-1:0]          wr_data;
    logic [COLOR_W-1:0]          rd_data;
    logic signed [STEP_W-1:0]    step_next;
    logic                        rev_next;

    assign cfg_ready    = 1'b1;
    assign cfg_fire     = cfg_valid && cfg_ready;
    assign in_ready     = (state_reg == ST_IDLE);
    assign in_fire      = in_valid && in_ready;
    assign render_start = in_fire && (opcode == OP_TICK);
    // result register frees up this cycle or is already empty
    assign resp_load    = (state_reg == ST_RESP) && (!out_valid_reg || out_ready);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode          <= MODE_FADE;
            cfg_reg.color_a       <= COLOR_A_RESET;
            cfg_reg.color_b       <= '0;
            cfg_reg.eye_size      <= EYE_SIZE_RESET;
            cfg_reg.rainbow_chase <= 1'b0;
            start_reverse_reg     <= 1'b0;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_EFFECT_MODE:   cfg_reg.mode          <= cfg_data[MODE_W-1:0];
                REG_COLOR_A:       cfg_reg.color_a       <= cfg_data;
                REG_COLOR_B:       cfg_reg.color_b       <= cfg_data;
                REG_EYE_SIZE:      cfg_reg.eye_size      <= cfg_data[CH_W-1:0];
                REG_START_REVERSE: start_reverse_reg     <= cfg_data[0];
                REG_RAINBOW_CHASE: cfg_reg.rainbow_chase <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // animation step and direction: an effect change restarts the animation,
    // otherwise the step moves once at the end of each rendered frame, but stays put for an unused effect code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            rev_reg  <= 1'b0;
        end
        else if (cfg_fire && (cfg_index == REG_EFFECT_MODE))
        begin
            step_reg <= '0;
            rev_reg  <= (cfg_data[MODE_W-1:0] == MODE_SCAN) ? 1'b0 : start_reverse_reg;
        end
        else if (render_done)
        begin
            step_reg <= step_next;
            rev_reg  <= rev_next;
        end
    end

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            out_valid_reg   <= 1'b0;
            pixel_color_reg <= '0;
            step_now_reg    <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !resp_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        idx_reg   <= pixel_index;
                        state_reg <= (opcode == OP_TICK) ? ST_RENDER : ST_READ;
                    end
                end
                ST_RENDER:
                begin
                    if (render_done)
                    begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:   state_reg <= ST_RESP;
                ST_RESP:
                begin
                    if (resp_load)
                    begin
                        out_valid_reg   <= 1'b1;
                        // pixels past the strip end read as black
                        pixel_color_reg <= ({1'b0, idx_reg} < NUM_PIX_W) ? rd_data : '0;
                        step_now_reg    <= step_reg[OUT_STEP_W-1:0];
                        state_reg       <= ST_IDLE;
                    end
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_color = pixel_color_reg;
    assign step_now    = step_now_reg;

    lpg_render #(
        .NUM_PIXELS (NUM_PIXELS)
    ) u_render (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (render_start),
        .cfg     (cfg_reg),
        .step    (step_reg),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .done    (render_done)
    );

    lpg_frame_mem #(
        .NUM_PIXELS (NUM_PIXELS)
    ) u_frame_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (state_reg == ST_READ),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    lpg_step_unit #(
        .NUM_PIXELS (NUM_PIXELS)
    ) u_step_unit (
        .mode      (cfg_reg.mode),
        .eye_size  (cfg_reg.eye_size),
        .step      (step_reg),
        .rev       (rev_reg),
        .step_next (step_next),
        .rev_next  (rev_next)
    );

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the LED strip pattern generator: directed and random traffic.
`timescale 1ns / 1ps

module tb_top
    import lpg_pkg::*;
();

    // Strip length used for the DUT and for the local frame mirror.
    localparam int N_PIX        = 256;
    // A tick sweeps all N_PIX pixels before its result is valid; leave some slack.
    localparam int DRAIN_CYCLES = N_PIX + 8;
    // Slowest legal run is roughly 650 items, each with the longest send gap, a
    // full tick and the longest result stall; take a few times that.
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_ITEMS = 550;
    // Long forward run so the rainbow step wraps past its period of 255.
    localparam int LONG_RUN     = 265;
    localparam int SEND_GAP_MAX = 300;
    localparam int SINK_GAP_MAX = 80;

    // Register indexes past the end of the register map; writes there are ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    // Effect codes with no effect behind them.
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    typedef struct {
        logic [COLOR_W-1:0]           color;
        logic signed [OUT_STEP_W-1:0] step;
    } pixel_result_t;

    typedef struct {
        logic             op;
        logic [IDX_W-1:0] idx;
    } strip_req_t;

    // ------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         cfg_valid   = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index   = '0;
    logic [COLOR_W-1:0]           cfg_data    = '0;
    logic                         in_valid    = 1'b0;
    logic                         in_ready;
    logic                         opcode      = OP_TICK;
    logic [IDX_W-1:0]             pixel_index = '0;
    logic                         out_valid;
    logic                         out_ready   = 1'b0;
    logic [COLOR_W-1:0]           pixel_color;
    logic signed [OUT_STEP_W-1:0] step_now;

    led_strip_pattern_generator_top #(
        .NUM_PIXELS (N_PIX)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .pixel_index (pixel_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_color (pixel_color),
        .step_now    (step_now)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Frame mirror: our own copy of the buffer, step, direction and registers
    // ------------------------------------------------------------------
    logic [COLOR_W-1:0] strip_mirror [N_PIX];
    int                 step_mirror;
    bit                 reverse_mirror;
    bit                 start_rev_mirror;
    lpg_cfg_t           regs_mirror;

    strip_req_t    req_queue[$];        // items waiting for the driver
    pixel_result_t expected_pixels[$];  // predicted results, oldest first

    int  mismatches    = 0;
    int  ticks_seen    = 0;
    int  reads_seen    = 0;
    int  reg_writes    = 0;
    int  phases_run    = 0;
    int  items_queued  = 0;
    int  cycle_count   = 0;
    bit  steady_phase  = 1'b0;  // no idling on either side while set

    function automatic void reset_mirror();
        for (int i = 0; i < N_PIX; i++)
            strip_mirror[i] = '0;
        step_mirror                = 0;
        reverse_mirror             = 1'b0;
        start_rev_mirror           = 1'b0;
        regs_mirror.mode           = MODE_FADE;
        regs_mirror.color_a        = COLOR_A_RESET;
        regs_mirror.color_b        = '0;
        regs_mirror.eye_size       = EYE_SIZE_RESET;
        regs_mirror.rainbow_chase  = 1'b0;
    endfunction

    // Three-segment color wheel: red->blue, blue->green, green->red.
    function automatic logic [COLOR_W-1:0] wheel_color(input int pos);
        int p;
        p = 255 - (pos & 255);
        if (p < 85)
            return {CH_W'(255 - p * 3), CH_W'(0), CH_W'(p * 3)};
        if (p < 170)
        begin
            p = p - 85;
            return {CH_W'(0), CH_W'(p * 3), CH_W'(255 - p * 3)};
        end
        p = p - 170;
        return {CH_W'(p * 3), CH_W'(255 - p * 3), CH_W'(0)};
    endfunction

    // Fade scaling (step * c) >> 8, black while the step is negative, capped at full.
    function automatic logic [CH_W-1:0] fade_level(input int s, input logic [CH_W-1:0] c);
        int v;
        if (s < 0)
            return '0;
        v = (s * int'(c)) >> 8;
        return (v > 255) ? CH_W'(255) : CH_W'(v);
    endfunction

    // Off-strip pixel writes vanish.
    function automatic void put_pixel(input int i, input logic [COLOR_W-1:0] c);
        if (i >= 0 && i < N_PIX)
            strip_mirror[i] = c;
    endfunction

    function automatic void bounce_step(input int limit);
        if (!reverse_mirror)
        begin
            step_mirror++;
            if (step_mirror > limit)
                reverse_mirror = 1'b1;
        end
        else
        begin
            step_mirror--;
            if (step_mirror <= 0)
                reverse_mirror = 1'b0;
        end
    endfunction

    function automatic void wrap_step(input int period);
        if (!reverse_mirror)
        begin
            step_mirror++;
            if (step_mirror >= period)
                step_mirror = 0;
        end
        else
        begin
            step_mirror--;
            if (step_mirror <= 0)
                step_mirror = period - 1;
        end
    endfunction

    // One frame of the current effect, then the step advance.
    function automatic void render_frame();
        int                 s;
        int                 e;
        logic [CH_W-1:0]    r;
        logic [CH_W-1:0]    g;
        logic [CH_W-1:0]    b;
        logic [COLOR_W-1:0] dim;
        s = step_mirror;
        {r, g, b} = regs_mirror.color_a;
        case (regs_mirror.mode)
            MODE_FADE:
            begin
                for (int i = 0; i < N_PIX; i++)
                    put_pixel(i, {fade_level(s, r), fade_level(s, g), fade_level(s, b)});
                bounce_step(256 + 1 - 1);
            end
            MODE_SCAN:
            begin
                e   = int'(regs_mirror.eye_size);
                dim = {CH_W'(r / 10), CH_W'(g / 10), CH_W'(b / 10)};
                for (int i = 0; i < N_PIX; i++)
                    strip_mirror[i] = '0;
                for (int i = s + 1; i <= s + e; i++)
                    put_pixel(i, regs_mirror.color_a);
                put_pixel(s, dim);
                put_pixel(s + e + 1, dim);
                // limit goes negative for eyes of N_PIX - 1 pixels or more
                bounce_step(N_PIX - e - 2);
            end
            MODE_WIPE:
            begin
                if (s < N_PIX)
                    put_pixel(s, regs_mirror.color_a);
                else
                    put_pixel(s - N_PIX, '0);
                wrap_step(2 * N_PIX);
            end
            MODE_RAINBOW:
            begin
                for (int i = 0; i < N_PIX; i++)
                    put_pixel(i, wheel_color(i * 256 / N_PIX + s));
                wrap_step(255);
            end
            MODE_CHASE:
            begin
                for (int i = 0; i < N_PIX; i++)
                begin
                    if ((i + s) % 3 == 0)
                        put_pixel(i, regs_mirror.rainbow_chase ?
                                     wheel_color(i * 256 / N_PIX + s) : regs_mirror.color_a);
                    else
                        put_pixel(i, regs_mirror.color_b);
                end
                wrap_step(N_PIX);
            end
            default: ;  // unused effect codes: frame and step untouched
        endcase
    endfunction

    function automatic pixel_result_t predict_access(input logic op, input logic [IDX_W-1:0] idx);
        pixel_result_t res;
        if (op == OP_TICK)
            render_frame();
        res.color = (int'(idx) < N_PIX) ? strip_mirror[idx] : '0;
        res.step  = step_mirror[OUT_STEP_W-1:0];
        return res;
    endfunction

    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [COLOR_W-1:0]   data);
        case (idx)
            REG_EFFECT_MODE:
            begin
                regs_mirror.mode = data[MODE_W-1:0];
                step_mirror      = 0;
                // scanner always sweeps forward first
                reverse_mirror   = (regs_mirror.mode == MODE_SCAN) ? 1'b0 : start_rev_mirror;
            end
            REG_COLOR_A:       regs_mirror.color_a       = data;
            REG_COLOR_B:       regs_mirror.color_b       = data;
            REG_EYE_SIZE:      regs_mirror.eye_size      = data[CH_W-1:0];
            REG_START_REVERSE: start_rev_mirror          = data[0];
            REG_RAINBOW_CHASE: regs_mirror.rainbow_chase = data[0];
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    // Mostly back-to-back, sometimes a short pause, rarely a long hole.
    function automatic int pick_pause(input int max_long);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        if (roll < 99)
            return $urandom_range(4, 20);
        return $urandom_range(21, max_long);
    endfunction

    // ------------------------------------------------------------------
    // Driver: pops pending items and presents them with random gaps
    // ------------------------------------------------------------------
    int         send_gap = 0;
    strip_req_t next_req;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else if (!in_valid || in_ready)
        begin
            // current transaction (if any) completes at this edge
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap--;
            end
            else if (req_queue.size() > 0)
            begin
                next_req = req_queue.pop_front();
                in_valid    <= 1'b1;
                opcode      <= next_req.op;
                pixel_index <= next_req.idx;
                send_gap = steady_phase ? 0 : pick_pause(SEND_GAP_MAX);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: mirrors register writes, predicts each accepted input
    // transaction, checks each accepted result, and stalls the result side
    // ------------------------------------------------------------------
    int            sink_stall = 0;
    pixel_result_t oldest;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            reset_mirror();
            out_ready <= 1'b0;
            sink_stall = 0;
        end
        else
        begin
            // results first: a result is loaded only after its input has moved the
            // sequencer out of idle, so it never belongs to an input taken at the same edge
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch("result with nothing outstanding",
                                    longint'(pixel_color), longint'(0));
                end
                else
                begin
                    oldest = expected_pixels.pop_front();
                    if (pixel_color !== oldest.color)
                        report_mismatch("pixel_color", longint'(pixel_color),
                                        longint'(oldest.color));
                    if (step_now !== oldest.step)
                        report_mismatch("step_now", longint'(step_now), longint'(oldest.step));
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                apply_reg_write(cfg_index, cfg_data);
                reg_writes++;
            end

            if (in_valid && in_ready)
            begin
                expected_pixels.push_back(predict_access(opcode, pixel_index));
                if (opcode == OP_TICK)
                    ticks_seen++;
                else
                    reads_seen++;
            end

            if (sink_stall > 0)
            begin
                out_ready <= 1'b0;
                sink_stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                sink_stall = steady_phase ? 0 : pick_pause(SINK_GAP_MAX);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_pixels.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(input logic op, input logic [IDX_W-1:0] idx);
        strip_req_t req;
        req.op  = op;
        req.idx = idx;
        req_queue.push_back(req);
    endtask

    // Register write transaction; only issued while nothing is in flight.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Every item yields a result, so an empty expectation queue means idle.
    task automatic settle();
        while (req_queue.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [COLOR_W-1:0] pick_color();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return COLOR_W'($urandom);
    endfunction

    // Small eyes most often, plus the wide end where the bounce limit goes negative.
    function automatic logic [COLOR_W-1:0] pick_eye();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            return COLOR_W'($urandom_range(1, 8));
        if (roll < 6)
            return COLOR_W'($urandom_range(9, 64));
        if (roll < 8)
            return COLOR_W'($urandom_range(240, 255));
        if (roll == 8)
            return '0;
        return COLOR_W'($urandom);
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode();
        if ($urandom_range(0, 9) == 0)
            return MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        return MODE_W'($urandom_range(MODE_FADE, MODE_CHASE));
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return IDX_W'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int  n;
        int  tick_pct;
        bit  long_done;
        long_done = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Buffer is black after reset, step at zero; default fade starts black too.
        push_item(OP_READ, '0);
        push_item(OP_READ, '1);
        push_item(OP_TICK, 8'h80);
        push_item(OP_TICK, '0);
        push_item(OP_READ, '1);
        settle();

        // Direction register alone does nothing until the effect is rewritten;
        // then a reverse fade dips to step -1 and bounces back.
        write_reg(REG_COLOR_A, '1);
        write_reg(REG_START_REVERSE, 24'd1);
        write_reg(REG_EFFECT_MODE, COLOR_W'(MODE_FADE));
        push_item(OP_TICK, '0);
        push_item(OP_TICK, '1);
        settle();

        // Scanner with an eye one pixel narrower than the strip: the far edge falls off the end.
        write_reg(REG_EYE_SIZE, 24'd255);
        write_reg(REG_EFFECT_MODE, COLOR_W'(MODE_SCAN));
        push_item(OP_TICK, 8'd1);
        push_item(OP_TICK, '0);
        push_item(OP_READ, '1);
        settle();

        // Empty eye: only the two dimmed edge pixels light up.
        write_reg(REG_EYE_SIZE, '0);
        write_reg(REG_COLOR_A, 24'hF0_64_0A);
        write_reg(REG_EFFECT_MODE, COLOR_W'(MODE_SCAN));
        push_item(OP_TICK, '0);
        push_item(OP_TICK, 8'd2);
        settle();

        // Reverse wipe wraps to the top at once and then blanks from the far end.
        write_reg(REG_COLOR_A, 24'h12_34_56);
        write_reg(REG_EFFECT_MODE, COLOR_W'(MODE_WIPE));
        push_item(OP_TICK, '0);
        push_item(OP_TICK, '1);
        push_item(OP_READ, '0);
        settle();

        write_reg(REG_START_REVERSE, '0);
        write_reg(REG_EFFECT_MODE, COLOR_W'(MODE_RAINBOW));
        push_item(OP_TICK, '0);
        push_item(OP_TICK, '1);
        settle();

        // Chase with wheel colors on the lit pixels over a white background.
        write_reg(REG_COLOR_B, '1);
        write_reg(REG_RAINBOW_CHASE, 24'd1);
        write_reg(REG_EFFECT_MODE, COLOR_W'(MODE_CHASE));
        push_item(OP_TICK, '0);
        push_item(OP_TICK, 8'd1);
        push_item(OP_TICK, 8'd2);
        settle();

        // Writes past the register map are dropped; an unused effect code
        // leaves both the frame and the step alone on a tick.
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '1);
        write_reg(REG_EFFECT_MODE, COLOR_W'(MODE_SPARE_HI));
        push_item(OP_TICK, 8'd3);
        push_item(OP_READ, 8'd5);
        settle();

        // Random phases: fresh registers while idle, then a burst of items.
        while (items_queued < RANDOM_ITEMS)
        begin
            steady_phase = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1))
                write_reg(REG_COLOR_A, pick_color());
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_COLOR_B, pick_color());
            if ($urandom_range(0, 1))
                write_reg(REG_EYE_SIZE, pick_eye());
            if ($urandom_range(0, 1))
                write_reg(REG_START_REVERSE, COLOR_W'($urandom));
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_RAINBOW_CHASE, COLOR_W'($urandom));
            if ($urandom_range(0, 9) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, COLOR_W'($urandom));

            if (!long_done && phases_run == 1)
            begin
                // one long forward rainbow so the step wraps past its period
                write_reg(REG_START_REVERSE, '0);
                write_reg(REG_EFFECT_MODE, COLOR_W'(MODE_RAINBOW));
                n        = LONG_RUN;
                tick_pct = 100;
                long_done = 1'b1;
            end
            else
            begin
                // mode written last so the step reset picks up the new direction;
                // sometimes left alone so the animation carries on
                if ($urandom_range(0, 4) != 0)
                    write_reg(REG_EFFECT_MODE, COLOR_W'(pick_mode()));
                n        = $urandom_range(6, 30);
                tick_pct = $urandom_range(30, 80);
            end

            for (int k = 0; k < n; k++)
                push_item(($urandom_range(1, 100) <= tick_pct) ? OP_TICK : OP_READ, pick_index());
            items_queued += n;
            settle();
            phases_run++;
        end

        steady_phase = 1'b0;
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d frame ticks and %0d pixel reads", ticks_seen, reads_seen);
        $display("over %0d random setups with %0d register writes, %0d mismatches",
                 phases_run, reg_writes, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/lpg_pkg.sv
hw/rtl/lpg_frame_mem.sv
hw/rtl/lpg_render.sv
hw/rtl/lpg_step_unit.sv
hw/rtl/led_strip_pattern_generator_top.sv
tb/sv/tb_top.sv
